// ----- rtl/bpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpl_pkg: shared constants and types for the blocked posting list lookup
// Status codes, opcodes, read-address selects and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bpl_pkg;

	localparam int STORE_DEPTH_DEF = 4096;

	// varbyte coding
	localparam int GROUP_BITS = 7;
	localparam int SHIFT_MAX  = 63;
	localparam int SHIFT_LIM  = 32;	// groups at or above this bit are dropped

	// list metadata positions
	localparam int META_T     = 0;
	localparam int META_B     = 1;
	localparam int META_L     = 2;
	localparam int META_COUNT = 3;

	// stream layout
	localparam int IN_DATA_W  = 40;	// code_byte(8), doc_id(31), pad
	localparam int IN_USER_W  = 2;	// opcode, start_of_list
	localparam int OUT_DATA_W = 32;	// frequency(31), pad
	localparam int OUT_USER_W = 3;	// status(2), overflowed
	localparam int ID_W       = 31;
	localparam int FREQ_W     = 31;
	localparam int WORD_W     = 32;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_T,
		RD_B,
		RD_L,
		RD_HEAD,
		RD_ID,
		RD_FREQ
	} rd_sel_t;

	typedef struct packed {
		logic    load;		// take one code byte
		logic    cap_id;	// latch query id, clear frequency
		rd_sel_t rd_sel;
		logic    cap_t;
		logic    cap_b;
		logic    cap_l;
		logic    chk1;		// range checks, b*(t-1)
		logic    head_init;
		logic    head_next;
		logic    blk_prev;	// search block before current head
		logic    blk_last;	// search last block
		logic    j_next;
		logic    freq_cap;
		logic    res_load;
		status_t res_code;
	} cmd_t;

	typedef struct packed {
		logic count_lt3;
		logic bad;
		logic id_lt_rd;
		logic id_eq_rd;
		logic i_zero;
		logic i_last;
		logic j_last;
		logic last_blk;
		logic out_busy;
	} stat_t;

endpackage

// ----- rtl/bpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpl_ctrl: query sequencer
// Steps a lookup through metadata reads, head scan and block searches.
// ----------------------------------------------------------------------------
module bpl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            opcode,
	output logic            in_ready,
	input  bpl_pkg::stat_t  stat,
	output bpl_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_CHK1,
		S_CHK2,
		S_HRD,
		S_HCMP,
		S_HNEXT,
		S_BRD,
		S_BCMP,
		S_FCAP,
		S_RES
	} state_t;

	state_t             state_q, state_nxt;
	bpl_pkg::status_t   code_q, code_nxt;

	always_comb begin
		state_nxt        = state_q;
		code_nxt         = code_q;
		in_ready         = 1'b0;
		cmd              = '0;
		cmd.rd_sel       = bpl_pkg::RD_NONE;
		cmd.res_code     = code_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == bpl_pkg::OP_QUERY) begin
						cmd.cap_id = 1'b1;
						state_nxt  = S_CHK0;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_CHK0: begin
				if (stat.count_lt3) begin
					code_nxt  = bpl_pkg::ST_INVALID;
					state_nxt = S_RES;
				end else begin
					cmd.rd_sel = bpl_pkg::RD_T;
					state_nxt  = S_RD1;
				end
			end
			S_RD1: begin
				cmd.rd_sel = bpl_pkg::RD_B;
				cmd.cap_t  = 1'b1;
				state_nxt  = S_RD2;
			end
			S_RD2: begin
				cmd.rd_sel = bpl_pkg::RD_L;
				cmd.cap_b  = 1'b1;
				state_nxt  = S_RD3;
			end
			S_RD3: begin
				cmd.cap_l = 1'b1;
				state_nxt = S_CHK1;
			end
			S_CHK1: begin
				cmd.chk1  = 1'b1;
				state_nxt = S_CHK2;
			end
			S_CHK2: begin
				if (stat.bad) begin
					code_nxt  = bpl_pkg::ST_INVALID;
					state_nxt = S_RES;
				end else begin
					cmd.head_init = 1'b1;
					state_nxt     = S_HRD;
				end
			end
			S_HRD: begin
				cmd.rd_sel = bpl_pkg::RD_HEAD;
				state_nxt  = S_HCMP;
			end
			S_HCMP: begin
				if (stat.id_lt_rd) begin
					if (stat.i_zero) begin
						code_nxt  = bpl_pkg::ST_NOT_FOUND;
						state_nxt = S_RES;
					end else begin
						cmd.blk_prev = 1'b1;
						state_nxt    = S_BRD;
					end
				end else begin
					state_nxt = S_HNEXT;
				end
			end
			S_HNEXT: begin
				if (stat.i_last) begin
					cmd.blk_last = 1'b1;
					state_nxt    = S_BRD;
				end else begin
					cmd.head_next = 1'b1;
					state_nxt     = S_HRD;
				end
			end
			S_BRD: begin
				cmd.rd_sel = bpl_pkg::RD_ID;
				state_nxt  = S_BCMP;
			end
			S_BCMP: begin
				if (stat.id_eq_rd) begin
					cmd.rd_sel = bpl_pkg::RD_FREQ;
					state_nxt  = S_FCAP;
				end else if (!stat.j_last) begin
					cmd.j_next = 1'b1;
					state_nxt  = S_BRD;
				end else if (stat.last_blk) begin
					code_nxt  = bpl_pkg::ST_NOT_FOUND;
					state_nxt = S_RES;
				end else begin
					state_nxt = S_HNEXT;
				end
			end
			S_FCAP: begin
				cmd.freq_cap = 1'b1;
				code_nxt     = bpl_pkg::ST_FOUND;
				state_nxt    = S_RES;
			end
			S_RES: begin
				if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= bpl_pkg::ST_FOUND;
		end else begin
			state_q <= state_nxt;
			code_q  <= code_nxt;
		end
	end

endmodule

// ----- rtl/bpl_dp.sv -----
// ----------------------------------------------------------------------------
// bpl_dp: decode and lookup datapath
// Varbyte decoder, number store, metadata/address registers, result register.
// ----------------------------------------------------------------------------
module bpl_dp #(
	parameter int STORE_DEPTH = bpl_pkg::STORE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpl_pkg::cmd_t               cmd,
	output bpl_pkg::stat_t              stat,
	input  logic                        start_of_list,
	input  logic [7:0]                  code_byte,
	input  logic [bpl_pkg::ID_W-1:0]    doc_id,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [bpl_pkg::FREQ_W-1:0]  frequency,
	output logic [1:0]                  status,
	output logic                        overflowed
);

	localparam int CW = $clog2(STORE_DEPTH + 1);	// counts up to depth
	localparam int AW = $clog2(STORE_DEPTH);	// store address
	localparam int PW = 2 * CW;			// b*(t-1)
	localparam int NW = PW + 3;			// needed length
	localparam int WW = bpl_pkg::WORD_W;

	// store
	logic [WW-1:0] mem [STORE_DEPTH];
	logic [WW-1:0] rd_q;
	logic [AW-1:0] raddr;
	logic          mem_we;

	// decoder state
	logic [CW-1:0] count_q;
	logic [WW-1:0] partial_q;
	logic [5:0]    shift_q;
	logic          ovf_q;

	// query registers
	logic [bpl_pkg::ID_W-1:0]   id_q;
	logic [bpl_pkg::FREQ_W-1:0] freq_q;
	logic [WW-1:0] t_q, b_q, l_q;
	logic          bad_q;
	logic [PW-1:0] prod_s1;
	logic [AW-1:0] head_q, prev_q, base_q;
	logic [CW-1:0] i_q, j_q, n_q;
	logic          last_q;

	// result register
	logic                       out_valid_q;
	logic [bpl_pkg::FREQ_W-1:0] out_freq_q;
	logic [1:0]                 out_status_q;
	logic                       out_ovf_q;

	// decoder next values
	logic [CW-1:0] eff_count;
	logic [WW-1:0] eff_partial, add_val, new_val;
	logic [5:0]    eff_shift, shift_nxt;
	logic [6:0]    shift_sum;
	logic          eff_ovf, room;

	always_comb begin
		eff_count   = start_of_list ? '0 : count_q;
		eff_partial = start_of_list ? '0 : partial_q;
		eff_shift   = start_of_list ? '0 : shift_q;
		eff_ovf     = start_of_list ? 1'b0 : ovf_q;
		add_val     = (eff_shift < 6'(bpl_pkg::SHIFT_LIM)) ?
			(WW'(code_byte[6:0]) << eff_shift[4:0]) : '0;
		new_val     = eff_partial + add_val;
		shift_sum   = 7'(eff_shift) + 7'(bpl_pkg::GROUP_BITS);
		shift_nxt   = (shift_sum > 7'(bpl_pkg::SHIFT_MAX)) ?
			6'(bpl_pkg::SHIFT_MAX) : shift_sum[5:0];
		room        = eff_count < CW'(STORE_DEPTH);
		mem_we      = cmd.load & code_byte[7] & room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			partial_q <= '0;
			shift_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.load) begin
			if (code_byte[7]) begin
				count_q   <= room ? eff_count + CW'(1) : eff_count;
				ovf_q     <= eff_ovf | ~room;
				partial_q <= '0;
				shift_q   <= '0;
			end else begin
				count_q   <= eff_count;
				ovf_q     <= eff_ovf;
				partial_q <= new_val;
				shift_q   <= shift_nxt;
			end
		end
	end

	// address generation
	logic [CW:0]   two_b;
	logic [CW+1:0] head_sum;
	logic [AW-1:0] blk_addr, frq_addr;

	always_comb begin
		two_b    = {b_q[CW-1:0], 1'b0};
		head_sum = (CW+2)'(head_q) + (CW+2)'(two_b);
		blk_addr = AW'((CW+1)'(base_q) + (CW+1)'(j_q));
		frq_addr = AW'((CW+2)'(base_q) + (CW+2)'(j_q) + (CW+2)'(n_q));
		case (cmd.rd_sel)
			bpl_pkg::RD_T:    raddr = AW'(bpl_pkg::META_T);
			bpl_pkg::RD_B:    raddr = AW'(bpl_pkg::META_B);
			bpl_pkg::RD_L:    raddr = AW'(bpl_pkg::META_L);
			bpl_pkg::RD_HEAD: raddr = head_q;
			bpl_pkg::RD_ID:   raddr = blk_addr;
			bpl_pkg::RD_FREQ: raddr = frq_addr;
			default:          raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[eff_count[AW-1:0]] <= new_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	// query registers (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.cap_id) begin
			id_q   <= doc_id;
			freq_q <= '0;
		end
		if (cmd.freq_cap) begin
			freq_q <= rd_q[bpl_pkg::FREQ_W-1:0];
		end
		if (cmd.cap_t) begin
			t_q <= rd_q;
		end
		if (cmd.cap_b) begin
			b_q <= rd_q;
		end
		if (cmd.cap_l) begin
			l_q <= rd_q;
		end
		if (cmd.chk1) begin
			bad_q   <= (t_q == '0) || (b_q == '0) || (l_q == '0) ||
				(t_q > WW'(STORE_DEPTH)) || (b_q > WW'(STORE_DEPTH)) || (l_q > b_q);
			prod_s1 <= PW'(b_q[CW-1:0]) * PW'(t_q[CW-1:0] - CW'(1));
		end
		if (cmd.head_init) begin
			head_q <= AW'(bpl_pkg::META_COUNT);
			i_q    <= '0;
		end
		if (cmd.head_next) begin
			prev_q <= head_q;
			head_q <= AW'(head_sum);
			i_q    <= i_q + CW'(1);
		end
		if (cmd.blk_prev) begin
			base_q <= prev_q;
			n_q    <= b_q[CW-1:0];
			j_q    <= '0;
			last_q <= 1'b0;
		end
		if (cmd.blk_last) begin
			base_q <= head_q;
			n_q    <= l_q[CW-1:0];
			j_q    <= '0;
			last_q <= 1'b1;
		end
		if (cmd.j_next) begin
			j_q <= j_q + CW'(1);
		end
	end

	// status back to the sequencer
	logic [NW-1:0] need;
	logic [WW-1:0] id_w;

	always_comb begin
		need = NW'(bpl_pkg::META_COUNT) + NW'({prod_s1, 1'b0}) +
			NW'({l_q[CW-1:0], 1'b0});
		id_w = {1'b0, id_q};
		stat.count_lt3 = count_q < CW'(bpl_pkg::META_COUNT);
		stat.bad       = bad_q || (NW'(count_q) < need);
		stat.id_lt_rd  = id_w < rd_q;
		stat.id_eq_rd  = id_w == rd_q;
		stat.i_zero    = i_q == '0;
		stat.i_last    = ((CW+1)'(i_q) + (CW+1)'(1)) >= (CW+1)'(t_q[CW-1:0]);
		stat.j_last    = ((CW+1)'(j_q) + (CW+1)'(1)) >= (CW+1)'(n_q);
		stat.last_blk  = last_q;
		stat.out_busy  = out_valid_q & ~out_ready;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_freq_q   <= freq_q;
			out_status_q <= cmd.res_code;
			out_ovf_q    <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign frequency  = out_freq_q;
	assign status     = out_status_q;
	assign overflowed = out_ovf_q;

endmodule

// ----- rtl/blocked_posting_list_lookup.sv -----
// ----------------------------------------------------------------------------
// blocked_posting_list_lookup: varbyte posting list loader and doc id lookup
// Loads a variable-byte coded blocked posting list into a number store and
// answers frequency queries by scanning block heads and searching blocks.
// ----------------------------------------------------------------------------
//
//  channel  dir  beats            carries
//  -------  ---  ---------------  ------------------------------------------
//  s_axis   in   load or query    tuser: opcode, start_of_list
//                                 tdata: code_byte, doc_id
//  m_axis   out  one per query    tdata: frequency; tuser: status, overflowed
//
// Loads stream back to back while no query is in progress.
// A query reads the three metadata words, checks them, scans the block heads
// and searches blocks for the id, reading its frequency when found; with
// fewer than three stored numbers it answers invalid. Every step is bound by
// the store's single read port.
// No clearing pass: only entries below the fill count are ever read.
// A finished result waits in the output register; loads and the next query
// are accepted meanwhile, and a query result stalls only on a full output.
//
module blocked_posting_list_lookup #(
	parameter int STORE_DEPTH = bpl_pkg::STORE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bpl_pkg::IN_DATA_W-1:0]    s_axis_tdata,	// code_byte[7:0], doc_id[38:8]
	input  logic [bpl_pkg::IN_USER_W-1:0]    s_axis_tuser,	// opcode[0], start_of_list[1]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bpl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,	// frequency[30:0]
	output logic [bpl_pkg::OUT_USER_W-1:0]   m_axis_tuser	// status[1:0], overflowed[2]
);

	bpl_pkg::cmd_t  cmd;
	bpl_pkg::stat_t stat;

	logic [bpl_pkg::FREQ_W-1:0] frequency;
	logic [1:0]                 status;
	logic                       overflowed;

	bpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.opcode   (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpl_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.start_of_list (s_axis_tuser[1]),
		.code_byte     (s_axis_tdata[7:0]),
		.doc_id        (s_axis_tdata[38:8]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.frequency     (frequency),
		.status        (status),
		.overflowed    (overflowed)
	);

	assign m_axis_tdata = {1'b0, frequency};
	assign m_axis_tuser = {overflowed, status};

	// result never overwrites a beat still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("result loaded over a stalled output beat");

	// sequencer issues at most one datapath step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.cap_id, cmd.cap_t, cmd.cap_b, cmd.cap_l, cmd.chk1,
			cmd.head_init, cmd.head_next, cmd.blk_prev, cmd.blk_last, cmd.j_next,
			cmd.freq_cap, cmd.res_load}))
		else $error("conflicting datapath commands");

	// an accepted query holds off further input
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == bpl_pkg::OP_QUERY)
		|=> !s_axis_tready)
		else $error("input accepted during a query");

endmodule
